>>> rtl/reentrant_mutex_fifo_handoff_macros.svh
// ----------------------------------------------------------------------------
// Mutex lock manager assertion macros
// Shorthand for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef REENTRANT_MUTEX_FIFO_HANDOFF_MACROS_SVH
`define REENTRANT_MUTEX_FIFO_HANDOFF_MACROS_SVH

// Same-cycle implication.
`define RMFH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lock manager check failed");

// Next-cycle implication.
`define RMFH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lock manager check failed");

`endif

>>> rtl/rmfh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex lock manager package
// Request opcodes, result status codes, datapath actions and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package rmfh_pkg;

    localparam int DEF_WAITER_DEPTH   = 16;
    localparam int DEF_THREAD_ID_BITS = 16;
    localparam int DEF_NEST_BITS      = 16;

    // Request opcodes
    localparam logic [1:0] OP_LOCK   = 2'd0;
    localparam logic [1:0] OP_TRY    = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Result status codes
    localparam logic [3:0] ST_ACQUIRED   = 4'd0;
    localparam logic [3:0] ST_REENTERED  = 4'd1;
    localparam logic [3:0] ST_BUSY       = 4'd2;
    localparam logic [3:0] ST_QUEUED     = 4'd3;
    localparam logic [3:0] ST_STILL_HELD = 4'd4;
    localparam logic [3:0] ST_FREED      = 4'd5;
    localparam logic [3:0] ST_HANDED_OFF = 4'd6;
    localparam logic [3:0] ST_QUEUE_FULL = 4'd7;
    localparam logic [3:0] ST_NOT_HELD   = 4'd8;

    // Datapath actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_GRANT    = 3'd1;
    localparam logic [2:0] ACT_NEST_INC = 3'd2;
    localparam logic [2:0] ACT_ENQ      = 3'd3;
    localparam logic [2:0] ACT_NEST_DEC = 3'd4;
    localparam logic [2:0] ACT_HANDOFF  = 3'd5;
    localparam logic [2:0] ACT_FREE     = 3'd6;

    typedef struct packed {
        logic       capture;
        logic       commit;
        logic [2:0] act;
        logic [3:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       owner_valid;
        logic       is_owner;
        logic       nest_max;
        logic       nest_gt1;
        logic       fifo_full;
        logic       fifo_empty;
    } t_dp_stat;

endpackage

>>> rtl/rmfh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex lock manager datapath
// Request register, owner and nesting state, waiter FIFO memory and the
// result register.
// ----------------------------------------------------------------------------
module rmfh_dp
    import rmfh_pkg::*;
#(
    parameter int WAITER_DEPTH   = DEF_WAITER_DEPTH,
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS,
    parameter int NEST_BITS      = DEF_NEST_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_dp_cmd                   i_cmd,
    input  logic [1:0]                i_opcode,
    input  logic [THREAD_ID_BITS-1:0] i_thread_id,
    output t_dp_stat                  o_stat,
    output logic [3:0]                o_status,
    output logic                      o_wake_valid,
    output logic [THREAD_ID_BITS-1:0] o_wake_thread,
    output logic [NEST_BITS-1:0]      o_nest_depth
);

    localparam int PTR_W  = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
    localparam int FILL_W = $clog2(WAITER_DEPTH + 1);
    localparam logic [PTR_W-1:0]     LAST_SLOT = PTR_W'(WAITER_DEPTH - 1);
    localparam logic [FILL_W-1:0]    FULL_FILL = FILL_W'(WAITER_DEPTH);
    localparam logic [NEST_BITS-1:0] NEST_ONE  = NEST_BITS'(1);

    logic [1:0]                r_req_op;
    logic [THREAD_ID_BITS-1:0] r_req_tid;

    logic                      r_owner_valid, n_owner_valid;
    logic [THREAD_ID_BITS-1:0] r_owner_id,    n_owner_id;
    logic [NEST_BITS-1:0]      r_nest,        n_nest;
    logic [PTR_W-1:0]          r_head,        n_head;
    logic [PTR_W-1:0]          r_tail,        n_tail;
    logic [FILL_W-1:0]         r_fill,        n_fill;

    logic [THREAD_ID_BITS-1:0] r_fifo_mem [WAITER_DEPTH];
    logic [THREAD_ID_BITS-1:0] r_head_data;

    logic [3:0]                r_status;
    logic                      r_wake_valid;
    logic [THREAD_ID_BITS-1:0] r_wake_thread;
    logic [NEST_BITS-1:0]      r_nest_depth;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] ptr);
        return (ptr == LAST_SLOT) ? '0 : ptr + PTR_W'(1);
    endfunction

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_op  <= i_opcode;
            r_req_tid <= i_thread_id;
        end
    end

    assign o_stat.op          = r_req_op;
    assign o_stat.owner_valid = r_owner_valid;
    assign o_stat.is_owner    = (r_owner_id == r_req_tid);
    assign o_stat.nest_max    = &r_nest;
    assign o_stat.nest_gt1    = (r_nest > NEST_ONE);
    assign o_stat.fifo_full   = (r_fill == FULL_FILL);
    assign o_stat.fifo_empty  = (r_fill == '0);

    always_comb begin
        n_owner_valid = r_owner_valid;
        n_owner_id    = r_owner_id;
        n_nest        = r_nest;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        case (i_cmd.act)
            ACT_GRANT: begin
                n_owner_valid = 1'b1;
                n_owner_id    = r_req_tid;
                n_nest        = NEST_ONE;
            end
            ACT_NEST_INC: begin
                n_nest = r_nest + NEST_ONE;
            end
            ACT_ENQ: begin
                n_tail = next_slot(r_tail);
                n_fill = r_fill + FILL_W'(1);
            end
            ACT_NEST_DEC: begin
                n_nest = r_nest - NEST_ONE;
            end
            ACT_HANDOFF: begin
                n_head     = next_slot(r_head);
                n_fill     = r_fill - FILL_W'(1);
                n_owner_id = r_head_data;
                n_nest     = NEST_ONE;
            end
            ACT_FREE: begin
                n_owner_valid = 1'b0;
                n_owner_id    = '0;
                n_nest        = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid <= 1'b0;
            r_owner_id    <= '0;
            r_nest        <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
        end else if (i_cmd.commit) begin
            r_owner_valid <= n_owner_valid;
            r_owner_id    <= n_owner_id;
            r_nest        <= n_nest;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_fill        <= n_fill;
        end
    end

    // Waiter memory: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && (i_cmd.act == ACT_ENQ)) begin
            r_fifo_mem[r_tail] <= r_req_tid;
        end
        r_head_data <= r_fifo_mem[r_head];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status      <= i_cmd.status;
            r_wake_valid  <= (i_cmd.act == ACT_HANDOFF);
            r_wake_thread <= (i_cmd.act == ACT_HANDOFF) ? r_head_data : '0;
            r_nest_depth  <= n_nest;
        end
    end

    assign o_status      = r_status;
    assign o_wake_valid  = r_wake_valid;
    assign o_wake_thread = r_wake_thread;
    assign o_nest_depth  = r_nest_depth;

endmodule

>>> rtl/rmfh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex lock manager controller
// Sequences accept and decide, picks the datapath action and owns the
// handshake on both channels.
// ----------------------------------------------------------------------------
module rmfh_ctrl
    import rmfh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_IDLE   = 1'b0;
    localparam logic S_DECIDE = 1'b1;

    logic       r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic [2:0] act;
    logic [3:0] status;

    // Pick the outcome of the held request
    always_comb begin
        act    = ACT_NONE;
        status = ST_BUSY;
        case (i_stat.op)
            OP_LOCK, OP_TRY: begin
                if (i_stat.owner_valid && i_stat.is_owner) begin
                    if (!i_stat.nest_max) begin
                        act    = ACT_NEST_INC;
                        status = ST_REENTERED;
                    end
                end else if (!i_stat.owner_valid) begin
                    act    = ACT_GRANT;
                    status = ST_ACQUIRED;
                end else if (i_stat.op == OP_TRY) begin
                    status = ST_BUSY;
                end else if (i_stat.fifo_full) begin
                    status = ST_QUEUE_FULL;
                end else begin
                    act    = ACT_ENQ;
                    status = ST_QUEUED;
                end
            end
            OP_UNLOCK: begin
                if (!i_stat.owner_valid) begin
                    status = ST_NOT_HELD;
                end else if (i_stat.nest_gt1) begin
                    act    = ACT_NEST_DEC;
                    status = ST_STILL_HELD;
                end else if (!i_stat.fifo_empty) begin
                    act    = ACT_HANDOFF;
                    status = ST_HANDED_OFF;
                end else begin
                    act    = ACT_FREE;
                    status = ST_FREED;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.commit  = 1'b0;
        o_cmd.act     = ACT_NONE;
        o_cmd.status  = status;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op == OP_NONE) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    o_cmd.commit = 1'b1;
                    o_cmd.act    = act;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/reentrant_mutex_fifo_handoff.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Recursive mutex lock manager with FIFO handoff
// Grants, nests, queues and releases one recursive mutex for many threads.
// ----------------------------------------------------------------------------
// Each beat on the input channel is one request (lock, try-lock or unlock
// from a thread) and produces exactly one result beat, except opcode 3,
// which is dropped silently. A request is first accepted, then decided and
// committed. The decide step needs the oldest waiter's id, which comes out
// of the registered read port of the waiter memory, and no new request is
// accepted until the held one leaves the decide step. The result sits in
// an output register, so a new request is accepted while the previous
// result still waits; the decide step holds only when that register is
// still full and stalled. No clearing pass runs after reset: the waiter
// memory is used only at entries the fill count covers.
// ----------------------------------------------------------------------------
module reentrant_mutex_fifo_handoff
    import rmfh_pkg::*;
#(
    parameter int WAITER_DEPTH   = DEF_WAITER_DEPTH,
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS,
    parameter int NEST_BITS      = DEF_NEST_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_opcode,
    input  logic [THREAD_ID_BITS-1:0] i_thread_id,
    // Result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [3:0]                o_status,
    output logic                      o_wake_valid,
    output logic [THREAD_ID_BITS-1:0] o_wake_thread,
    output logic [NEST_BITS-1:0]      o_nest_depth
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Controller: accept a beat, decide its outcome, hold on a full output
    rmfh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    // Datapath: owner, nesting count, waiter queue and result register
    rmfh_dp #(
        .WAITER_DEPTH   (WAITER_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS),
        .NEST_BITS      (NEST_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .i_opcode      (i_opcode),
        .i_thread_id   (i_thread_id),
        .o_stat        (dp_stat),
        .o_status      (o_status),
        .o_wake_valid  (o_wake_valid),
        .o_wake_thread (o_wake_thread),
        .o_nest_depth  (o_nest_depth)
    );

endmodule

>>> rtl/rmfh_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mutex lock manager port checker
// Watches the top-level ports over time; attached by bind.
// ----------------------------------------------------------------------------
`include "reentrant_mutex_fifo_handoff_macros.svh"

module rmfh_chk
    import rmfh_pkg::*;
#(
    parameter int THREAD_ID_BITS = DEF_THREAD_ID_BITS,
    parameter int NEST_BITS      = DEF_NEST_BITS
) (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [3:0]                o_status,
    input logic                      o_wake_valid,
    input logic [THREAD_ID_BITS-1:0] o_wake_thread,
    input logic [NEST_BITS-1:0]      o_nest_depth
);

    logic                   in_beat;
    logic                   out_held;
    logic                   wake_ok;
    logic                   free_out;
    logic                   free_clean;
    logic [NEST_BITS+3:0]   out_word;

    assign in_beat    = i_in_valid && !o_in_stall;
    assign out_held   = o_out_valid && i_out_stall;
    assign wake_ok    = (o_wake_valid == (o_status == ST_HANDED_OFF));
    assign free_out   = o_out_valid && (o_status == ST_FREED || o_status == ST_NOT_HELD);
    assign free_clean = (o_nest_depth == '0) && (o_wake_thread == '0);
    assign out_word   = {o_status, o_nest_depth};

    // One request at a time: a beat just taken holds off the next
    `RMFH_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, in_beat, o_in_stall)

    // A wake goes with a handoff and nothing else
    `RMFH_ASSERT_IMP(a_wake_is_handoff, i_clk, i_rst_n, o_out_valid, wake_ok)

    // A free mutex reports no nesting and wakes nobody
    `RMFH_ASSERT_IMP(a_free_is_empty, i_clk, i_rst_n, free_out, free_clean)

    // A stalled result holds
    `RMFH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

endmodule

bind reentrant_mutex_fifo_handoff rmfh_chk #(
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .NEST_BITS      (NEST_BITS)
) u_rmfh_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_wake_valid  (o_wake_valid),
    .o_wake_thread (o_wake_thread),
    .o_nest_depth  (o_nest_depth)
);
